@@ sv/ils_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ils_pkg;

  localparam int DEPTH  = 16;
  localparam int ELEM_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int FPOS_W = 4;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                func;
    logic [POS_W-1:0]   position;
    logic [ELEM_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  data;
    logic               found;
    logic [FPOS_W-1:0]  found_position;
    status_t            status;
    logic [CNT_W-1:0]   length;
  } out_req_t;

  typedef struct packed {
    logic               ins;
    logic               del;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic [ELEM_W-1:0]  value;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ sv/ils_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ils_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire ils_pkg::cell_ctl_t        ctl,
  input  wire logic [ils_pkg::ELEM_W-1:0] left_elem,
  input  wire logic [ils_pkg::ELEM_W-1:0] right_elem,
  output logic      [ils_pkg::ELEM_W-1:0] elem,
  output logic                           match,
  output logic      [ils_pkg::ELEM_W-1:0] rd_data
);

  localparam logic [ils_pkg::POS_W-1:0] MY_POS = ils_pkg::POS_W'(IDX);
  localparam logic [ils_pkg::CNT_W-1:0] MY_CNT = ils_pkg::CNT_W'(IDX);

  logic [ils_pkg::ELEM_W-1:0] elem_r;
  logic [ils_pkg::ELEM_W-1:0] elem_nxt;
  logic                       at_pos;
  logic                       after_pos;
  logic                       in_list;

  assign at_pos    = (ctl.pos == MY_POS);
  assign after_pos = (MY_POS > ctl.pos);
  assign in_list   = (MY_CNT < ctl.count);

  always_comb begin
    elem_nxt = elem_r;
    if (ctl.ins) begin
      if (at_pos) begin
        elem_nxt = ctl.value;
      end else if (after_pos) begin
        elem_nxt = left_elem;
      end
    end else if (ctl.del) begin
      if (at_pos || after_pos) begin
        elem_nxt = right_elem;
      end
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign elem    = elem_r;
  assign match   = in_list && (elem_r == ctl.value);
  assign rd_data = at_pos ? elem_r : '0;

endmodule
`default_nettype wire

@@ sv/indexed_list_store_unit.sv @@
// The result of an accepted request is registered into the output register at the edge that accepts it.
// Throughput: one request per cycle unless stalled; cells shift, match and read together.
// The output register stalls the input only while a held result is not taken.
// Reset: synchronous, active low; clears the list length and the output valid.
// Element storage is not cleared; entries at or above the length are never read.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_store_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ils_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ils_pkg::out_req_t      out_req
);

  localparam int D = ils_pkg::DEPTH;

  logic [ils_pkg::CNT_W-1:0]  count_r;
  logic [ils_pkg::CNT_W-1:0]  count_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  ils_pkg::out_req_t          out_req_r;
  ils_pkg::out_req_t          out_req_nxt;

  logic                       accept;
  logic                       rd_ok;
  logic                       ins_range;
  logic                       ins_full;
  ils_pkg::cell_ctl_t         ctl;

  logic [ils_pkg::ELEM_W-1:0] elem_w [D];
  logic [ils_pkg::ELEM_W-1:0] rd_w   [D];
  logic [D-1:0]               match_w;
  logic [D-1:0]               first_w;
  logic [ils_pkg::ELEM_W-1:0] rd_data;
  logic [ils_pkg::FPOS_W-1:0] fpos;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  assign rd_ok     = ({1'b0, in_req.position} < {1'b0, count_r});
  assign ins_range = ({1'b0, in_req.position} > {1'b0, count_r});
  assign ins_full  = (count_r == ils_pkg::CNT_W'(D));

  always_comb begin
    ctl.ins   = accept && (in_req.func == ils_pkg::OP_INSERT) && !ins_range && !ins_full;
    ctl.del   = accept && (in_req.func == ils_pkg::OP_DELETE) && rd_ok;
    ctl.pos   = in_req.position;
    ctl.count = count_r;
    ctl.value = in_req.value;
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    logic [ils_pkg::ELEM_W-1:0] left_w;
    logic [ils_pkg::ELEM_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = elem_w[g-1];
    end
    if (g == D-1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = elem_w[g+1];
    end
    ils_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_elem  (left_w),
      .right_elem (right_w),
      .elem       (elem_w[g]),
      .match      (match_w[g]),
      .rd_data    (rd_w[g])
    );
  end

  assign first_w = match_w & (~match_w + D'(1));

  always_comb begin
    rd_data = '0;
    fpos    = '0;
    for (int i = 0; i < D; i++) begin
      rd_data = rd_data | rd_w[i];
      if (first_w[i]) begin
        fpos = fpos | ils_pkg::FPOS_W'(i);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + ils_pkg::CNT_W'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - ils_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_req_nxt                = out_req_r;
    out_valid_nxt              = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_req_nxt.data           = '0;
      out_req_nxt.found          = 1'b0;
      out_req_nxt.found_position = '0;
      out_req_nxt.status         = ils_pkg::ST_OK;
      out_req_nxt.length         = count_nxt;
      unique case (in_req.func) inside
        ils_pkg::OP_GET, ils_pkg::OP_DELETE: begin
          if (rd_ok) begin
            out_req_nxt.data = rd_data;
          end else begin
            out_req_nxt.status = ils_pkg::ST_RANGE;
          end
        end
        ils_pkg::OP_LOCATE: begin
          out_req_nxt.found          = |match_w;
          out_req_nxt.found_position = fpos;
        end
        ils_pkg::OP_INSERT: begin
          if (ins_range) begin
            out_req_nxt.status = ils_pkg::ST_RANGE;
          end else if (ins_full) begin
            out_req_nxt.status = ils_pkg::ST_FULL;
          end
        end
        default: begin
          out_req_nxt.status = ils_pkg::ST_RANGE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule
`default_nettype wire

@@ sv/ils_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ils_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire ils_pkg::out_req_t out_req
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("held result changed");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_req.length <= 5'(ils_pkg::DEPTH))
    else $error("length beyond depth");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.found |-> out_req.status == ils_pkg::ST_OK && out_req.data == '0)
    else $error("locate result carries data or error");

  a_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.status != ils_pkg::ST_OK |-> !out_req.found && out_req.data == '0)
    else $error("error result carries data");

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (.*);
`default_nettype wire

@@ sim/ils_checker.sv @@
`timescale 1ns / 1ps
module tb_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  ils_pkg::in_req_t          in_req,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  ils_pkg::out_req_t         out_req,
  output int                        mismatch_count,
  output int                        pending_count,
  output logic [ils_pkg::CNT_W-1:0] list_length
);

  logic [ils_pkg::ELEM_W-1:0] list_elems [ils_pkg::DEPTH];
  ils_pkg::out_req_t          expected_results [$];

  function automatic ils_pkg::out_req_t apply_request(input ils_pkg::in_req_t r);
    ils_pkg::out_req_t res;
    int                p;
    res = '0;
    p = int'(r.position);
    case (r.func)
      ils_pkg::OP_GET: begin
        if (p < int'(list_length)) res.data = list_elems[p];
        else res.status = ils_pkg::ST_RANGE;
      end
      ils_pkg::OP_LOCATE: begin
        for (int i = 0; i < int'(list_length); i++) begin
          if (!res.found && list_elems[i] == r.value) begin
            res.found = 1'b1;
            res.found_position = i[ils_pkg::FPOS_W-1:0];
          end
        end
      end
      ils_pkg::OP_INSERT: begin
        if (p > int'(list_length)) begin
          res.status = ils_pkg::ST_RANGE;
        end else if (int'(list_length) == ils_pkg::DEPTH) begin
          res.status = ils_pkg::ST_FULL;
        end else begin
          for (int i = int'(list_length); i > p; i--) list_elems[i] = list_elems[i-1];
          list_elems[p] = r.value;
          list_length = list_length + 1'b1;
        end
      end
      default: begin
        if (p < int'(list_length)) begin
          res.data = list_elems[p];
          for (int i = p; i + 1 < int'(list_length); i++) list_elems[i] = list_elems[i+1];
          list_length = list_length - 1'b1;
        end else begin
          res.status = ils_pkg::ST_RANGE;
        end
      end
    endcase
    res.length = list_length;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ils_pkg::ELEM_W-1:0] want,
                             input logic [ils_pkg::ELEM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    ils_pkg::out_req_t want;
    if (!rst_n) begin
      list_length = '0;
      expected_results.delete();
      pending_count = 0;
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, out_req);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("data", want.data, out_req.data);
          check_field("found", ils_pkg::ELEM_W'(want.found), ils_pkg::ELEM_W'(out_req.found));
          check_field("found_position", ils_pkg::ELEM_W'(want.found_position),
                      ils_pkg::ELEM_W'(out_req.found_position));
          check_field("status", ils_pkg::ELEM_W'(want.status),
                      ils_pkg::ELEM_W'(out_req.status));
          check_field("length", ils_pkg::ELEM_W'(want.length),
                      ils_pkg::ELEM_W'(out_req.length));
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_req));
      pending_count = expected_results.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int ITEMS_PER_PHASE = 480;
  localparam int MODE_SPAN       = 48;
  localparam int HOLD_CYCLES     = 200;
  localparam int IDLE_LIMIT      = 2000;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  ils_pkg::in_req_t          in_req;
  logic                      out_valid;
  logic                      out_stall;
  ils_pkg::out_req_t         out_req;
  int                        mismatch_count;
  int                        pending_count;
  logic [ils_pkg::CNT_W-1:0] list_length;
  int                        idle_pct;
  int                        stall_pct;
  bit                        hold_req;

  indexed_list_store_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  tb_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_req        (out_req),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .list_length    (list_length)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic ils_pkg::in_req_t list_request(input ils_pkg::op_t f,
                                                    input logic [ils_pkg::POS_W-1:0] p,
                                                    input logic [ils_pkg::ELEM_W-1:0] v);
    ils_pkg::in_req_t r;
    r.func = f;
    r.position = p;
    r.value = v;
    return r;
  endfunction

  function automatic ils_pkg::in_req_t make_request(input bit filling);
    ils_pkg::in_req_t r;
    int               len;
    int               roll;
    len = int'(list_length);
    roll = $urandom_range(99);
    if (roll < 50) r.func = ils_pkg::OP_INSERT;
    else if (roll < 65) r.func = ils_pkg::OP_DELETE;
    else if (roll < 80) r.func = ils_pkg::OP_GET;
    else r.func = ils_pkg::OP_LOCATE;
    if (!filling) begin
      if (r.func == ils_pkg::OP_INSERT) r.func = ils_pkg::OP_DELETE;
      else if (r.func == ils_pkg::OP_DELETE) r.func = ils_pkg::OP_INSERT;
    end
    if ($urandom_range(9) == 0) r.position = ils_pkg::POS_W'($urandom_range(31));
    else if (r.func == ils_pkg::OP_INSERT) r.position = ils_pkg::POS_W'($urandom_range(len));
    else if (len > 0) r.position = ils_pkg::POS_W'($urandom_range(len - 1));
    else r.position = ils_pkg::POS_W'($urandom_range(31));
    case ($urandom_range(9))
      0:          r.value = '0;
      1:          r.value = '1;
      2, 3, 4, 5: r.value = 32'h5A5A_0000 + $urandom_range(5);
      default:    r.value = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_request(input ils_pkg::in_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off the receiver on request, else stall at random
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(list_request(ils_pkg::OP_GET, 0, 0));
    send_request(list_request(ils_pkg::OP_DELETE, 0, 0));
    send_request(list_request(ils_pkg::OP_LOCATE, 0, 0));
    send_request(list_request(ils_pkg::OP_INSERT, 1, 32'h1234_5678));
    // fill alternately at the front and at the end
    for (int i = 0; i < ils_pkg::DEPTH; i++)
      send_request(list_request(ils_pkg::OP_INSERT, ils_pkg::POS_W'(i[0] ? i : 0),
                                i * 32'h1111_1111));
    send_request(list_request(ils_pkg::OP_INSERT, 16, 32'hDEAD_BEEF));
    send_request(list_request(ils_pkg::OP_INSERT, 17, 32'hDEAD_BEEF));
    send_request(list_request(ils_pkg::OP_LOCATE, 31, 32'hFFFF_FFFF));
    send_request(list_request(ils_pkg::OP_GET, 31, 0));
    send_request(list_request(ils_pkg::OP_DELETE, 15, 0));
    send_request(list_request(ils_pkg::OP_DELETE, 0, 0));
    send_request(list_request(ils_pkg::OP_LOCATE, 0, 32'h1234_5678));
    send_request(list_request(ils_pkg::OP_GET, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 100) hold_req = 1'b1;
        send_request(make_request((n / MODE_SPAN) % 2 == 0));
      end
    end
    in_valid <= 1'b0;

    wait (pending_count == 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
sv/ils_pkg.sv
sv/ils_cell.sv
sv/indexed_list_store_unit.sv
sv/ils_checker.sv
sim/ils_checker.sv
sim/tb_top.sv
